>>> rtl/msb_first_bit_reader_unit_macros.svh
// assertion macros for the msb-first bit reader
// used by rtl/msb_first_bit_reader_unit.sv; expects clk and rst_n in scope
`ifndef MSB_FIRST_BIT_READER_UNIT_MACROS_SVH
`define MSB_FIRST_BIT_READER_UNIT_MACROS_SVH

`ifndef SYNTH

// condition holds in the same cycle
`define MSBR_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MSBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define MSBR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define MSBR_ASSERT_NOW(label, cond, msg)
`define MSBR_ASSERT_NEXT(label, ante, cons, msg)
`define MSBR_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

>>> rtl/msbr_pkg.sv
// shared codes for the msb-first bit reader: action codes and sequencer states
// no dependencies
package msbr_pkg;

    typedef logic [1:0] action_t;
    typedef logic [1:0] state_t;

    // action codes carried by each input word
    localparam action_t ACT_RESTART = 2'd0;
    localparam action_t ACT_APPEND  = 2'd1;
    localparam action_t ACT_READ    = 2'd2;
    localparam action_t ACT_SKIP    = 2'd3;

    // sequencer states
    localparam state_t ST_IDLE  = 2'd0;
    localparam state_t ST_FETCH = 2'd1;
    localparam state_t ST_DONE  = 2'd2;

    // bits per stored byte
    localparam int BYTE_BITS = 8;

endpackage

>>> rtl/msbr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module msbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/msb_first_bit_reader_unit.sv
// msb-first bit reader: restart, append a byte, read up to 64 bits, skip bits
// depends on msbr_pkg, msbr_ram and msb_first_bit_reader_unit_macros.svh
// sequence: restart/append/skip pass from accept to the done state, which loads the output
// register; a read taking n bits at bit offset o first fetches ceil((o + n) / 8) bytes (up to 9)
// busy: a new word is taken only in the idle state; the done state waits while out_ready is low
// reset: counts and handshakes clear at once; buffer contents stay undefined
module msb_first_bit_reader_unit #(
    parameter int BUFFER_BYTES  = 256,
    parameter int MAX_READ_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  byte_value,
    input  logic [11:0] bit_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] value,
    output logic        ok,
    output logic [11:0] bits_left
);

    `include "msb_first_bit_reader_unit_macros.svh"

    localparam int AW  = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int BLW = $clog2(BUFFER_BYTES + 1);
    localparam int PW  = BLW + 3;
    localparam int CW  = (PW > 12) ? PW : 12;
    localparam int ACCW = 72;

    // control registers
    msbr_pkg::state_t  state_reg, state_next;
    logic [BLW-1:0]    bytes_reg, bytes_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [3:0]        rem_reg, rem_next;
    logic              out_valid_reg, out_valid_next;

    // payload registers
    msbr_pkg::action_t act_reg, act_next;
    logic              ok_reg, ok_next;
    logic [2:0]        off_reg, off_next;
    logic [2:0]        trail_reg, trail_next;
    logic              first_reg, first_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [ACCW-1:0]   acc_reg, acc_next;
    logic [63:0]       value_reg, value_next;
    logic              ok_out_reg, ok_out_next;
    logic [11:0]       left_out_reg, left_out_next;

    // ram ports
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [7:0]        ram_rd_data;

    // request decode
    logic              accept;
    logic [PW-1:0]     total;
    logic [PW-1:0]     left;
    logic [11:0]       cnt_sat;
    logic              fits;
    logic [11:0]       take;
    logic [BLW-1:0]    idx;
    logic [6:0]        end_sum;
    logic [7:0]        nb_sum;
    logic [3:0]        nb;
    logic [7:0]        first_byte;

    msbr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (bytes_reg[AW-1:0]),
        .wr_data (byte_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_ready = (state_reg == msbr_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    // remaining bits and the count actually taken
    always_comb
    begin
        total   = {bytes_reg, 3'b000};
        left    = total - pos_reg;
        cnt_sat = bit_count;
        if ((action == msbr_pkg::ACT_READ) && (bit_count > 12'(MAX_READ_BITS)))
        begin
            cnt_sat = 12'(MAX_READ_BITS);
        end
        fits    = (CW'(cnt_sat) <= CW'(left));
        take    = fits ? cnt_sat : 12'(CW'(left));
        idx     = pos_reg[PW-1:3];
        end_sum = 7'(pos_reg[2:0]) + take[6:0];
        nb_sum  = 8'(end_sum) + 8'd7;
        nb      = nb_sum[6:3];
    end

    // leading bits before the read position are cleared in the first byte
    assign first_byte = first_reg ? (ram_rd_data & (8'hFF >> off_reg)) : ram_rd_data;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        bytes_next     = bytes_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        act_next       = act_reg;
        ok_next        = ok_reg;
        off_next       = off_reg;
        trail_next     = trail_reg;
        first_next     = first_reg;
        addr_next      = addr_reg;
        acc_next       = acc_reg;
        value_next     = value_reg;
        ok_out_next    = ok_out_reg;
        left_out_next  = left_out_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = addr_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            msbr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    act_next   = action;
                    ok_next    = 1'b1;
                    acc_next   = '0;
                    state_next = msbr_pkg::ST_DONE;
                    case (action)
                        msbr_pkg::ACT_RESTART:
                        begin
                            bytes_next = '0;
                            pos_next   = '0;
                        end
                        msbr_pkg::ACT_APPEND:
                        begin
                            if (CW'(bytes_reg) < CW'(BUFFER_BYTES))
                            begin
                                ram_wr_en  = 1'b1;
                                bytes_next = bytes_reg + BLW'(1);
                            end
                            else
                            begin
                                ok_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            // read or skip: advance by the bits taken
                            ok_next  = fits;
                            pos_next = PW'(CW'(pos_reg) + CW'(take));
                            if ((action == msbr_pkg::ACT_READ) && (nb != 4'd0))
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = idx[AW-1:0];
                                addr_next   = idx[AW-1:0] + AW'(1);
                                rem_next    = nb;
                                off_next    = pos_reg[2:0];
                                trail_next  = 3'd0 - end_sum[2:0];
                                first_next  = 1'b1;
                                state_next  = msbr_pkg::ST_FETCH;
                            end
                        end
                    endcase
                end
            end
            msbr_pkg::ST_FETCH:
            begin
                // one byte a cycle into the accumulator
                acc_next   = {acc_reg[ACCW-9:0], first_byte};
                first_next = 1'b0;
                rem_next   = rem_reg - 4'd1;
                if (rem_reg == 4'd1)
                begin
                    state_next = msbr_pkg::ST_DONE;
                end
                else
                begin
                    ram_rd_en = 1'b1;
                    addr_next = addr_reg + AW'(1);
                end
            end
            msbr_pkg::ST_DONE:
            begin
                // load the output word once the register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ok_out_next    = ok_reg;
                    left_out_next  = 12'(CW'(total - pos_reg));
                    if (act_reg == msbr_pkg::ACT_READ)
                    begin
                        value_next = 64'(acc_reg >> trail_reg);
                    end
                    else
                    begin
                        value_next = '0;
                    end
                    state_next = msbr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msbr_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msbr_pkg::ST_IDLE;
            bytes_reg     <= '0;
            pos_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bytes_reg     <= bytes_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        ok_reg       <= ok_next;
        off_reg      <= off_next;
        trail_reg    <= trail_next;
        first_reg    <= first_next;
        addr_reg     <= addr_next;
        acc_reg      <= acc_next;
        value_reg    <= value_next;
        ok_out_reg   <= ok_out_next;
        left_out_reg <= left_out_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign ok        = ok_out_reg;
    assign bits_left = left_out_reg;

    // checks
    `MSBR_ASSERT_NOW(a_pos_in_range, CW'(pos_reg) <= CW'(total), "bit position past loaded data")
    `MSBR_ASSERT_NOW(a_bytes_in_range, CW'(bytes_reg) <= CW'(BUFFER_BYTES), "byte count overflow")
    `MSBR_ASSERT_IMPL(a_fetch_read, state_reg == msbr_pkg::ST_FETCH, (rem_reg != 4'd0) && (act_reg == msbr_pkg::ACT_READ), "fetch without pending read bytes")
    `MSBR_ASSERT_NEXT(a_accept_busy, accept, !in_ready, "input taken while busy")

endmodule
